/* design/vxr_pkg.sv */
`default_nettype none
package vxr_pkg;

   // coordinate format
   localparam int COORD_WIDTH = 24;
   localparam int FRAC_BITS   = 12;
   localparam int ANGLE_WIDTH = 16;

   // trig values, signed Q1.15 in 17 bits
   localparam int TRIG_WIDTH = 17;
   localparam int TRIG_FRAC  = 15;
   localparam logic [TRIG_WIDTH-1:0] TRIG_ONE = TRIG_WIDTH'(32768);

   // product and sum widths of one rotated component
   localparam int PROD_WIDTH = COORD_WIDTH + TRIG_WIDTH;
   localparam int SUM_WIDTH  = PROD_WIDTH + 1;

   // beat widths
   localparam int VEC_WIDTH  = 3 * COORD_WIDTH;
   localparam int DATA_WIDTH = 2 * VEC_WIDTH;

   // polynomial for sin(u*pi/2), u in Q30
   localparam int Q30_WIDTH = 31;
   localparam int PROD_Q30_WIDTH = 2 * Q30_WIDTH;
   localparam logic [Q30_WIDTH-1:0] Q30_ONE = Q30_WIDTH'(1 << 30);
   localparam logic [Q30_WIDTH-1:0] K_C1  = Q30_WIDTH'(1686629713);
   localparam logic [Q30_WIDTH-1:0] K_C3  = Q30_WIDTH'(693598668);
   localparam logic [Q30_WIDTH-1:0] K_C5  = Q30_WIDTH'(85569306);
   localparam logic [Q30_WIDTH-1:0] K_C7  = Q30_WIDTH'(5026995);
   localparam logic [Q30_WIDTH-1:0] K_C9  = Q30_WIDTH'(172272);
   localparam logic [Q30_WIDTH-1:0] K_C11 = Q30_WIDTH'(3864);
   localparam int POLY_STEPS = 6;
   localparam int STEP_WIDTH = $clog2(POLY_STEPS + 1);

   // csr
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [TRIG_WIDTH-1:0]  trig_val_type;
   typedef logic signed [PROD_WIDTH-1:0]  prod_type;
   typedef logic signed [SUM_WIDTH-1:0]   sum_type;

   // x in the lowest bits
   typedef struct packed {
      coord_type z;
      coord_type y;
      coord_type x;
   } vec_type;

   typedef struct packed {
      trig_val_type cos_val;
      trig_val_type sin_val;
   } trig_type;

   typedef enum logic [1:0] {
      AXIS_X    = 2'd0,
      AXIS_Y    = 2'd1,
      AXIS_Z    = 2'd2,
      AXIS_NONE = 2'd3
   } axis_type;

   typedef enum logic {
      REG_ANGLE = 1'b0,
      REG_AXIS  = 1'b1
   } reg_idx_type;

   typedef enum logic [1:0] {
      TRIG_IDLE,
      TRIG_MUL,
      TRIG_ACC
   } trig_state_type;

   // coefficient subtracted at horner step idx, innermost first
   function automatic logic [Q30_WIDTH-1:0] poly_coef(input logic [STEP_WIDTH-1:0] idx);
      logic [Q30_WIDTH-1:0] k;
      case (idx)
         STEP_WIDTH'(1): k = K_C9;
         STEP_WIDTH'(2): k = K_C7;
         STEP_WIDTH'(3): k = K_C5;
         STEP_WIDTH'(4): k = K_C3;
         STEP_WIDTH'(5): k = K_C1;
         default:        k = K_C11;
      endcase
      return k;
   endfunction

   // drop the Q15 trig fraction, half rounds up, saturate to the coordinate range
   function automatic coord_type round_sat(input sum_type sum);
      sum_type t;
      coord_type r;
      t = (sum + SUM_WIDTH'(1 << (TRIG_FRAC - 1))) >>> TRIG_FRAC;
      if ((&t[SUM_WIDTH-1:COORD_WIDTH-1]) || !(|t[SUM_WIDTH-1:COORD_WIDTH-1])) begin
         r = t[COORD_WIDTH-1:0];
      end else if (t[SUM_WIDTH-1]) begin
         r = {1'b1, {(COORD_WIDTH-1){1'b0}}};
      end else begin
         r = {1'b0, {(COORD_WIDTH-1){1'b1}}};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

/* design/vertex_axis_rotation.sv */
// vertex_axis_rotation: rotates mesh vertices about a principal axis
//
// req_ channel: one beat per vertex, position and normal in tdata, tlast marks
// the final vertex of a mesh and comes out unchanged on rsp_tlast
// rsp_ channel: the rotated vertex, components rounded and saturated
// csr_ port: rotation_angle at byte 0 (2^16 is a full turn), rotation_axis
// at byte 4 (0 x, 1 y, 2 z, 3 pass through)
// the req beat is registered in the multiply stage, then summed, rounded and
// saturated into the output register that drives rsp_tvalid
// throughput: one vertex per cycle unless back-pressured or the trig unit is busy,
// two lanes (position, normal) each with four 17x24 multipliers working in parallel
// after a write to rotation_angle the sine/cosine unit runs its polynomial
// on one shared 31x31 multiplier, and req_tready stays low while it runs
// reset: angle 0, axis x, cos 1, sin 0, pipeline empty
// when rsp_tready is low the output register holds its beat and the multiply
// stage, if empty, still takes one more vertex before req_tready drops
`default_nettype none
module vertex_axis_rotation (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z from bit 0 up
   input  wire logic [vxr_pkg::DATA_WIDTH-1:0]     req_tdata,
   input  wire logic                               req_tlast,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // rot_pos_x, rot_pos_y, rot_pos_z, rot_norm_x, rot_norm_y, rot_norm_z
   // from bit 0 up
   output logic [vxr_pkg::DATA_WIDTH-1:0]          rsp_tdata,
   output logic                                    rsp_tlast,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [vxr_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [vxr_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [vxr_pkg::CSR_DATA_WIDTH-1:0]      csr_prdata,
   output logic                                    csr_pready
);
   import vxr_pkg::*;

   // configuration registers
   logic [ANGLE_WIDTH-1:0] angle_ff;
   axis_type axis_ff;
   logic csr_wr;
   reg_idx_type csr_idx;

   // trig unit
   trig_type trig;
   logic trig_busy;

   // pipeline control
   logic s1_valid_ff, s1_valid_in;
   logic s1_last_ff;
   logic out_valid_ff, out_valid_in;
   logic out_last_ff;
   logic [DATA_WIDTH-1:0] out_data_ff;
   logic s1_load, out_load, req_beat;

   vec_type pos_rot, norm_rot;

   assign csr_pready = 1'b1;
   assign csr_idx    = reg_idx_type'(csr_paddr[2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff <= '0;
         axis_ff  <= AXIS_X;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_ANGLE: angle_ff <= csr_pwdata[ANGLE_WIDTH-1:0];
            REG_AXIS:  axis_ff  <= axis_type'(csr_pwdata[1:0]);
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_ANGLE: csr_prdata = CSR_DATA_WIDTH'(angle_ff);
         REG_AXIS:  csr_prdata = CSR_DATA_WIDTH'(axis_ff);
         default:   csr_prdata = '0;
      endcase
   end

   // sine and cosine are rebuilt when the angle is written while the trig unit is idle
   vxr_trig_gen u_trig (
      .clock (clock),
      .reset (reset),
      .start (csr_wr && (csr_idx == REG_ANGLE)),
      .angle (csr_pwdata[ANGLE_WIDTH-1:0]),
      .trig  (trig),
      .busy  (trig_busy)
   );

   // output register frees when empty or taken, multiply stage when it can move on
   assign out_load   = !out_valid_ff || rsp_tready;
   assign s1_load    = !s1_valid_ff || out_load;
   assign req_tready = s1_load && !trig_busy;
   assign req_beat   = req_tvalid && req_tready;

   assign s1_valid_in  = s1_load ? req_beat : s1_valid_ff;
   assign out_valid_in = out_load ? s1_valid_ff : out_valid_ff;

   // position lane
   vxr_lane u_lane_pos (
      .clock (clock),
      .load  (s1_load),
      .vec   (vec_type'(req_tdata[VEC_WIDTH-1:0])),
      .axis  (axis_ff),
      .trig  (trig),
      .rot   (pos_rot)
   );

   // normal lane
   vxr_lane u_lane_norm (
      .clock (clock),
      .load  (s1_load),
      .vec   (vec_type'(req_tdata[DATA_WIDTH-1:VEC_WIDTH])),
      .axis  (axis_ff),
      .trig  (trig),
      .rot   (norm_rot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (s1_load) begin
         s1_last_ff <= req_tlast;
      end
      // merge both lanes into the output beat
      if (out_load) begin
         out_data_ff <= {norm_rot, pos_rot};
         out_last_ff <= s1_last_ff;
      end
   end

   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tvalid = out_valid_ff;

endmodule
`default_nettype wire

/* design/vxr_trig_gen.sv */
`default_nettype none
module vxr_trig_gen (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [vxr_pkg::ANGLE_WIDTH-1:0] angle,
   output vxr_pkg::trig_type                   trig,
   output logic                                busy
);
   import vxr_pkg::*;

   trig_state_type state_ff, state_in;
   logic [STEP_WIDTH-1:0] idx_ff, idx_in;
   logic half_ff, half_in;
   logic [1:0] quad_ff, quad_in;
   logic [Q30_WIDTH-1:0] u_ff, u_in;
   logic [Q30_WIDTH-1:0] u2_ff, u2_in;
   logic [Q30_WIDTH-1:0] acc_ff, acc_in;
   logic [PROD_Q30_WIDTH-1:0] prod_ff, prod_in;
   logic [TRIG_WIDTH-1:0] s0_ff, s0_in;
   trig_type trig_ff, trig_in;

   logic [Q30_WIDTH-1:0] op_a, op_b, prod_top;
   logic [Q30_WIDTH+1:0] rnd;
   logic [TRIG_WIDTH-1:0] mag;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= TRIG_IDLE;
         trig_ff.cos_val <= $signed(TRIG_ONE);
         trig_ff.sin_val <= '0;
      end else begin
         state_ff <= state_in;
         trig_ff  <= trig_in;
      end
      idx_ff  <= idx_in;
      half_ff <= half_in;
      quad_ff <= quad_in;
      u_ff    <= u_in;
      u2_ff   <= u2_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      s0_ff   <= s0_in;
   end

   // shared 31x31 multiplier, one product per mul cycle
   always_comb begin
      op_a = (idx_ff == STEP_WIDTH'(0) || idx_ff == STEP_WIDTH'(POLY_STEPS)) ? u_ff : u2_ff;
      op_b = (idx_ff == STEP_WIDTH'(0)) ? u_ff : acc_ff;
      prod_top = prod_ff[PROD_Q30_WIDTH-2:30];
      rnd = {2'b00, prod_top} + (Q30_WIDTH+2)'(1 << (TRIG_FRAC - 1));
      mag = rnd[TRIG_FRAC+TRIG_WIDTH-1:TRIG_FRAC];
      if (mag > TRIG_ONE) begin
         mag = TRIG_ONE;
      end
   end

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      half_in  = half_ff;
      quad_in  = quad_ff;
      u_in     = u_ff;
      u2_in    = u2_ff;
      acc_in   = acc_ff;
      prod_in  = prod_ff;
      s0_in    = s0_ff;
      trig_in  = trig_ff;
      unique case (state_ff)
         TRIG_IDLE: begin
            if (start) begin
               quad_in  = angle[ANGLE_WIDTH-1:ANGLE_WIDTH-2];
               u_in     = {1'b0, angle[ANGLE_WIDTH-3:0], {(32-ANGLE_WIDTH){1'b0}}};
               idx_in   = '0;
               half_in  = 1'b0;
               state_in = TRIG_MUL;
            end
         end
         TRIG_MUL: begin
            prod_in  = PROD_Q30_WIDTH'(op_a) * PROD_Q30_WIDTH'(op_b);
            state_in = TRIG_ACC;
         end
         TRIG_ACC: begin
            if (idx_ff == STEP_WIDTH'(0)) begin
               u2_in    = prod_top;
               acc_in   = K_C11;
               idx_in   = idx_ff + STEP_WIDTH'(1);
               state_in = TRIG_MUL;
            end else if (idx_ff != STEP_WIDTH'(POLY_STEPS)) begin
               acc_in   = poly_coef(idx_ff) - prod_top;
               idx_in   = idx_ff + STEP_WIDTH'(1);
               state_in = TRIG_MUL;
            end else if (!half_ff) begin
               // sine done, now the cosine from the complement
               s0_in    = mag;
               u_in     = Q30_ONE - u_ff;
               half_in  = 1'b1;
               idx_in   = '0;
               state_in = TRIG_MUL;
            end else begin
               case (quad_ff)
                  2'd0: begin
                     trig_in.cos_val = $signed(mag);
                     trig_in.sin_val = $signed(s0_ff);
                  end
                  2'd1: begin
                     trig_in.cos_val = -$signed(s0_ff);
                     trig_in.sin_val = $signed(mag);
                  end
                  2'd2: begin
                     trig_in.cos_val = -$signed(mag);
                     trig_in.sin_val = -$signed(s0_ff);
                  end
                  default: begin
                     trig_in.cos_val = $signed(s0_ff);
                     trig_in.sin_val = -$signed(mag);
                  end
               endcase
               state_in = TRIG_IDLE;
            end
         end
         default: state_in = TRIG_IDLE;
      endcase
   end

   assign trig = trig_ff;
   assign busy = (state_ff != TRIG_IDLE);

endmodule
`default_nettype wire

/* design/vxr_lane.sv */
`default_nettype none
module vxr_lane (
   input  wire logic               clock,
   input  wire logic               load,
   input  wire vxr_pkg::vec_type   vec,
   input  wire vxr_pkg::axis_type  axis,
   input  wire vxr_pkg::trig_type  trig,
   output vxr_pkg::vec_type        rot
);
   import vxr_pkg::*;

   prod_type p_ca_ff, p_mb_ff, p_ma_ff, p_cb_ff;
   prod_type p_ca_in, p_mb_in, p_ma_in, p_cb_in;
   vec_type vec_ff;
   axis_type axis_ff;

   coord_type a, b;
   trig_val_type m1, m2;
   coord_type o1, o2;

   // pick the pair of components in the rotation plane
   always_comb begin
      case (axis)
         AXIS_X:  begin a = vec.y; b = vec.z; end
         AXIS_Y:  begin a = vec.x; b = vec.z; end
         default: begin a = vec.x; b = vec.y; end
      endcase
      m1 = (axis == AXIS_Y) ? trig.sin_val : -trig.sin_val;
      m2 = -m1;
      p_ca_in = prod_type'(trig.cos_val) * prod_type'(a);
      p_mb_in = prod_type'(m1) * prod_type'(b);
      p_ma_in = prod_type'(m2) * prod_type'(a);
      p_cb_in = prod_type'(trig.cos_val) * prod_type'(b);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         p_ca_ff <= p_ca_in;
         p_mb_ff <= p_mb_in;
         p_ma_ff <= p_ma_in;
         p_cb_ff <= p_cb_in;
         vec_ff  <= vec;
         axis_ff <= axis;
      end
   end

   always_comb begin
      o1 = round_sat({p_ca_ff[PROD_WIDTH-1], p_ca_ff} + {p_mb_ff[PROD_WIDTH-1], p_mb_ff});
      o2 = round_sat({p_ma_ff[PROD_WIDTH-1], p_ma_ff} + {p_cb_ff[PROD_WIDTH-1], p_cb_ff});
      rot = vec_ff;
      case (axis_ff)
         AXIS_X: begin rot.y = o1; rot.z = o2; end
         AXIS_Y: begin rot.x = o1; rot.z = o2; end
         AXIS_Z: begin rot.x = o1; rot.y = o2; end
         default: rot = vec_ff;
      endcase
   end

endmodule
`default_nettype wire

/* dv/tb_vertex_axis_rotation.sv */
`timescale 1ns / 100ps
module tb_vertex_axis_rotation;
   import vxr_pkg::*;

   localparam int COORD_MAX   = 2 ** (COORD_WIDTH - 1) - 1;
   localparam int COORD_MIN   = -(2 ** (COORD_WIDTH - 1));
   // 4.0 in q12.12 times an odd q1.15 trig value lands exactly on a rounding tie
   localparam int HALF_LSB    = 2 ** (TRIG_FRAC - 1);
   localparam int PIPE_SLACK  = 4;     // extra wait once nothing is owed
   localparam int LONG_HOLD   = 64;    // receiver hold-off, long enough to back up the input
   localparam int STALL_LIMIT = 1000;  // cycles without any beat or csr access
   localparam int RANDOM_BEATS = 850;

   // one vertex as it travels on the wire: six coordinates packed x first, plus tlast
   typedef struct packed {
      logic                  last;
      logic [DATA_WIDTH-1:0] data;
   } vertex_type;

   // one row of the directed table
   typedef struct packed {
      logic        cfg;    // drain and reprogram before this vertex
      logic [31:0] angle;
      logic [31:0] axis;
      logic        echo;   // expected beat is the vertex itself
      vertex_type  v;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   logic [DATA_WIDTH-1:0]     req_tdata;   // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z
   logic                      req_tlast;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [DATA_WIDTH-1:0]     rsp_tdata;   // rot_pos_x .. rot_norm_z, x lowest
   logic                      rsp_tlast;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic                      csr_psel;
   logic                      csr_penable;
   logic                      csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   vertex_axis_rotation dut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #2 clock = ~clock;

   // shadow of the block's programmed state
   axis_type   axis_cfg;
   int         cos_q15;
   int         sin_q15;

   vertex_type   rotated_due [$];    // rotated vertices still owed by the block, oldest first
   stim_row_type stim_table [$];
   int           mismatch_count = 0;
   int           stall_cycles = 0;
   bit           req_burst = 1'b0;
   bit           rsp_burst = 1'b0;
   bit           rsp_hold_pending = 1'b0;
   string        coord_name [6] = '{"pos_x", "pos_y", "pos_z", "norm_x", "norm_y", "norm_z"};

   // ------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------

   // sin(u*pi/2) for u in q30, horner form with truncating products, rounded to q1.15
   function automatic int quarter_wave(longint unsigned u);
      longint unsigned u2;
      longint unsigned acc;
      longint unsigned r;
      u2  = (u * u) >> 30;
      acc = 64'(K_C11);
      acc = 64'(K_C9) - ((u2 * acc) >> 30);
      acc = 64'(K_C7) - ((u2 * acc) >> 30);
      acc = 64'(K_C5) - ((u2 * acc) >> 30);
      acc = 64'(K_C3) - ((u2 * acc) >> 30);
      acc = 64'(K_C1) - ((u2 * acc) >> 30);
      r = (u * acc) >> 30;
      r = (r + 64'd16384) >> TRIG_FRAC;
      if (r > 64'd32768) begin
         r = 64'd32768;
      end
      return int'(r);
   endfunction

   // top two angle bits give the quadrant, the rest the fraction of a quarter turn
   function automatic void load_angle(logic [31:0] value);
      logic [ANGLE_WIDTH-1:0] ang;
      longint unsigned        u;
      int                     s0;
      int                     c0;
      ang = value[ANGLE_WIDTH-1:0];
      u   = 64'(ang[ANGLE_WIDTH-3:0]);
      u   = u << (32 - ANGLE_WIDTH);
      s0  = quarter_wave(u);
      c0  = quarter_wave((64'd1 << 30) - u);
      case (ang[ANGLE_WIDTH-1 -: 2])
         2'd0: begin
            cos_q15 = c0;  sin_q15 = s0;
         end
         2'd1: begin
            cos_q15 = -s0; sin_q15 = c0;
         end
         2'd2: begin
            cos_q15 = -c0; sin_q15 = -s0;
         end
         default: begin
            cos_q15 = s0;  sin_q15 = -c0;
         end
      endcase
   endfunction

   // p*a + m*b back to q12.12: ties go towards plus infinity, then clamp
   function automatic coord_type blend(int p, coord_type a, int m, coord_type b);
      longint acc;
      longint hi;
      longint lo;
      hi  = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
      lo  = -hi - 1;
      acc = longint'(p) * longint'(a) + longint'(m) * longint'(b)
            + (longint'(1) <<< (TRIG_FRAC - 1));
      acc = acc >>> TRIG_FRAC;
      if (acc > hi) begin
         acc = hi;
      end
      if (acc < lo) begin
         acc = lo;
      end
      return coord_type'(acc);
   endfunction

   function automatic vertex_type rotate_vertex(vertex_type v);
      vertex_type r;
      coord_type  x;
      coord_type  y;
      coord_type  z;
      r = v;
      // position lane then normal lane, same matrix for both
      for (int b = 0; b < 6; b += 3) begin
         x = v.data[b * COORD_WIDTH +: COORD_WIDTH];
         y = v.data[(b + 1) * COORD_WIDTH +: COORD_WIDTH];
         z = v.data[(b + 2) * COORD_WIDTH +: COORD_WIDTH];
         case (axis_cfg)
            AXIS_X: begin
               r.data[(b + 1) * COORD_WIDTH +: COORD_WIDTH] = blend(cos_q15, y, -sin_q15, z);
               r.data[(b + 2) * COORD_WIDTH +: COORD_WIDTH] = blend(sin_q15, y, cos_q15, z);
            end
            AXIS_Y: begin
               r.data[b * COORD_WIDTH +: COORD_WIDTH]       = blend(cos_q15, x, sin_q15, z);
               r.data[(b + 2) * COORD_WIDTH +: COORD_WIDTH] = blend(-sin_q15, x, cos_q15, z);
            end
            AXIS_Z: begin
               r.data[b * COORD_WIDTH +: COORD_WIDTH]       = blend(cos_q15, x, -sin_q15, y);
               r.data[(b + 1) * COORD_WIDTH +: COORD_WIDTH] = blend(sin_q15, x, cos_q15, y);
            end
            default: begin
               // pass-through axis, vertex unchanged
            end
         endcase
      end
      return r;
   endfunction

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------

   // mostly short gaps, now and then a long one
   function automatic int idle_span();
      if ($urandom_range(0, 19) < 15) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic int next_gap();
      if (req_burst || $urandom_range(0, 1) == 0) begin
         return 0;
      end
      return idle_span();
   endfunction

   // extremes, small values, exact rounding ties and full-range noise
   function automatic coord_type rand_coord();
      case ($urandom_range(0, 9))
         0:       return coord_type'(COORD_MAX);
         1:       return coord_type'(COORD_MIN);
         2, 3:    return coord_type'(int'($urandom_range(0, 32767)) - 16384);
         4:       return coord_type'((int'($urandom_range(0, 15)) - 8) * HALF_LSB);
         default: return coord_type'($urandom);
      endcase
   endfunction

   task automatic add_row(logic cfg, logic [31:0] angle, logic [31:0] axis,
                          int px, int py, int pz, int nx, int ny, int nz,
                          logic last, logic echo);
      stim_row_type row;
      row.cfg    = cfg;
      row.angle  = angle;
      row.axis   = axis;
      row.echo   = echo;
      row.v.last = last;
      row.v.data = {coord_type'(nz), coord_type'(ny), coord_type'(nx),
                    coord_type'(pz), coord_type'(py), coord_type'(px)};
      stim_table.push_back(row);
   endtask

   // offer one vertex, hold it until the block takes it, then log what must come back
   task automatic push_vertex(vertex_type v, int gap, logic echo);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= v.data;
      req_tlast  <= v.last;
      do @(posedge clock); while (!req_tready);
      rotated_due.push_back(echo ? v : rotate_vertex(v));
      @(negedge clock);
   endtask

   // sender stops and waits for the block to run dry
   task automatic settle_block();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (rotated_due.size() != 0);
      repeat (PIPE_SLACK) @(negedge clock);
   endtask

   // setup phase, then access phase; shadow state follows at the accepting edge
   task automatic csr_write(reg_idx_type idx, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= CSR_ADDR_WIDTH'({idx, 2'b00});
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_ANGLE: load_angle(value);
         REG_AXIS:  axis_cfg = axis_type'(value[1:0]);
         default:   ;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // axis first: the angle write starts the trig unit, which then owns the block
   task automatic program_rotation(logic [31:0] angle, logic [31:0] axis);
      csr_write(REG_AXIS, axis);
      csr_write(REG_ANGLE, angle);
   endtask

   task automatic report_mismatch(string msg);
      $display("%0t: mismatch, %s", $time, msg);
      mismatch_count++;
   endtask

   // ------------------------------------------------------------------
   // result side: tready pattern and the scoreboard
   // ------------------------------------------------------------------

   initial begin
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         if (rsp_hold_pending) begin
            // long back-pressure, counted here while the sender keeps offering
            rsp_hold_pending = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end else if (rsp_burst) begin
            rsp_tready <= 1'b1;
            @(negedge clock);
         end else if ($urandom_range(0, 3) != 0) begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b0;
            repeat (idle_span()) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      vertex_type want;
      coord_type  got_c;
      coord_type  want_c;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (rotated_due.size() == 0) begin
            report_mismatch("result beat with nothing outstanding");
         end else begin
            want = rotated_due.pop_front();
            for (int k = 0; k < 6; k++) begin
               got_c  = rsp_tdata[k * COORD_WIDTH +: COORD_WIDTH];
               want_c = want.data[k * COORD_WIDTH +: COORD_WIDTH];
               if (got_c !== want_c) begin
                  report_mismatch($sformatf("%s got %0d expected %0d",
                                            coord_name[k], got_c, want_c));
               end
            end
            if (rsp_tlast !== want.last) begin
               report_mismatch($sformatf("tlast got %b expected %b", rsp_tlast, want.last));
            end
         end
      end
   end

   // watchdog: any beat or csr access restarts the count
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_psel && csr_penable)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------

   initial begin
      vertex_type  v;
      int          total;
      int          phase;
      int          n;
      int          mesh_left;
      logic [31:0] angle_val;
      logic [31:0] axis_val;

      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;

      // reset state: axis x, cos one, sin zero
      axis_cfg = AXIS_X;
      cos_q15  = 32768;
      sin_q15  = 0;

      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // directed rows; echo rows come back untouched because cos is one and sin zero,
      // or because the axis is pass-through
      //       cfg   angle          axis           pos_x      pos_y      pos_z
      //                                           norm_x     norm_y     norm_z     last echo
      add_row(1'b0, 0,             0,             0,         0,         0,
                                                  0,         0,         0,         1'b0, 1'b1);
      add_row(1'b0, 0,             0,             COORD_MAX, COORD_MAX, COORD_MAX,
                                                  COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, 1'b1);
      add_row(1'b0, 0,             0,             COORD_MIN, COORD_MIN, COORD_MIN,
                                                  COORD_MIN, COORD_MIN, COORD_MIN, 1'b0, 1'b1);
      add_row(1'b0, 0,             0,             COORD_MAX, COORD_MIN, COORD_MAX,
                                                  COORD_MIN, COORD_MAX, COORD_MIN, 1'b1, 1'b1);
      // pass-through axis at 45 degrees
      add_row(1'b1, 32'h2000,      32'(AXIS_NONE), COORD_MIN, COORD_MAX, COORD_MIN,
                                                  COORD_MAX, COORD_MIN, COORD_MAX, 1'b0, 1'b1);
      add_row(1'b0, 0,             0,             'h123456,  -'h5a5a5a, 'h0f0f0f,
                                                  -1,        1,         'h2aaaaa,  1'b1, 1'b1);
      // 45 degrees about x: opposite extremes saturate high and low
      add_row(1'b1, 32'h2000,      32'(AXIS_X),   0,         COORD_MAX, COORD_MIN,
                                                  0,         COORD_MIN, COORD_MAX, 1'b0, 1'b0);
      add_row(1'b0, 0,             0,             1,         -1,        1,
                                                  -1,        1,         -1,        1'b1, 1'b0);
      add_row(1'b1, 32'h6000,      32'(AXIS_Y),   COORD_MAX, 0,         COORD_MAX,
                                                  COORD_MIN, 0,         COORD_MIN, 1'b0, 1'b0);
      add_row(1'b0, 0,             0,             4096,      -4096,     -8192,
                                                  2048,      7,         -3,        1'b1, 1'b0);
      add_row(1'b1, 32'he000,      32'(AXIS_Z),   COORD_MAX, COORD_MAX, 0,
                                                  COORD_MIN, COORD_MAX, 0,         1'b0, 1'b0);
      add_row(1'b0, 0,             0,             -4096,     12345,     COORD_MAX,
                                                  1,         0,         COORD_MIN, 1'b1, 1'b0);
      // angle register at its top value
      add_row(1'b1, 32'hffff,      32'(AXIS_Z),   COORD_MAX, COORD_MIN, 5,
                                                  4096,      4096,      -5,        1'b0, 1'b0);
      // quadrant boundaries, where one trig value is a clamped one
      add_row(1'b1, 32'h4000,      32'(AXIS_Y),   COORD_MIN, 3,         COORD_MAX,
                                                  4096,      -1,        -4096,     1'b1, 1'b0);
      add_row(1'b1, 32'h8000,      32'(AXIS_X),   9,         COORD_MAX, COORD_MIN,
                                                  -9,        COORD_MIN, 1,         1'b0, 1'b0);
      add_row(1'b1, 32'hc000,      32'(AXIS_Z),   COORD_MIN, COORD_MIN, 2,
                                                  COORD_MAX, 100,       -2,        1'b1, 1'b0);
      // oversized writes keep only the register width; the angle lands on 22.5 degrees
      // about x, with half-lsb multiples in both signs
      add_row(1'b1, 32'hffff_1000, 32'hffff_fffc, 0,         HALF_LSB,  0,
                                                  0,         -HALF_LSB, 0,         1'b0, 1'b0);
      add_row(1'b0, 0,             0,             7,         3*HALF_LSB, 0,
                                                  -7,        -3*HALF_LSB, 1,       1'b1, 1'b0);
      add_row(1'b1, 0,             32'h7,         COORD_MAX, 0,         COORD_MIN,
                                                  -1,        COORD_MAX, 0,         1'b1, 1'b1);

      foreach (stim_table[i]) begin
         if (stim_table[i].cfg) begin
            settle_block();
            program_rotation(stim_table[i].angle, stim_table[i].axis);
         end
         push_vertex(stim_table[i].v, next_gap(), stim_table[i].echo);
      end

      // random phases: drain, reprogram, then a few meshes of random vertices
      total = 0;
      phase = 0;
      while (total < RANDOM_BEATS) begin
         settle_block();
         case ($urandom_range(0, 5))
            0:       angle_val = 32'h0;
            1:       angle_val = 32'hffff;
            2:       angle_val = 32'(int'($urandom_range(0, 3)) << (ANGLE_WIDTH - 2));
            default: angle_val = $urandom;
         endcase
         // every axis in turn, upper bits as noise
         axis_val = ($urandom & ~32'h3) | 32'(phase % 4);
         program_rotation(angle_val, axis_val);

         req_burst = (phase % 5 == 1);
         rsp_burst = req_burst;
         n = $urandom_range(10, 60);
         if (phase == 2) begin
            // receiver stalls long while the sender streams flat out
            req_burst        = 1'b1;
            rsp_burst        = 1'b0;
            rsp_hold_pending = 1'b1;
            n                = 40;
         end

         mesh_left = $urandom_range(1, 24);
         repeat (n) begin
            for (int k = 0; k < 6; k++) begin
               v.data[k * COORD_WIDTH +: COORD_WIDTH] = rand_coord();
            end
            // tlast on the final vertex of each mesh, with the odd stray flag
            v.last = (mesh_left == 1);
            if ($urandom_range(0, 19) == 0) begin
               v.last = ~v.last;
            end
            mesh_left--;
            if (mesh_left == 0) begin
               mesh_left = $urandom_range(1, 24);
            end
            push_vertex(v, next_gap(), 1'b0);
         end
         req_burst = 1'b0;
         rsp_burst = 1'b0;
         total += n;
         phase++;
      end

      req_tvalid <= 1'b0;
      do @(negedge clock); while (rotated_due.size() != 0);
      repeat (2 * PIPE_SLACK) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
